// ===== src/sap_pkg.sv =====
`default_nettype none
package sap_pkg;

  // axis lanes that carry state, and target fields on the result beat
  localparam int AXES  = 4;
  localparam int LANES = 4;

  localparam int ANGLE_W = 12;
  localparam int VEL_W   = 9;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 12'd4095;
  localparam logic [5:0]         SOFT_ZONE = 6'd40;

  typedef enum logic [2:0] {
    CFG_PARK_ANGLE     = 3'd0,
    CFG_VEL_CAP        = 3'd1,
    CFG_ACC_CAP        = 3'd2,
    CFG_SNAP_ZONE      = 3'd3,
    CFG_LEVEL_MAX_STEP = 3'd4
  } sap_cfg_idx_t;

  typedef struct packed {
    logic [11:0] park_angle;
    logic [7:0]  vel_cap;
    logic [7:0]  acc_cap;
    logic [5:0]  snap_zone;
    logic [7:0]  level_max_step;
  } sap_cfg_t;

  // pipeline control shared by all lanes
  typedef struct packed {
    logic load;     // input beat enters stage 1
    logic adv;      // stage 1 moves to the output register
    logic park;     // item in stage 1 is a park tick
    logic clr_vel;  // first park tick after another mode
  } sap_ctrl_t;

  // level midpoints per axis, right axes subtract the doubled yaw
  localparam logic [ANGLE_W-1:0] LANE_MID [0:LANES-1] = '{
    12'd2030, 12'd2060, 12'd2054, 12'd2000
  };
  localparam logic LANE_YAW_NEG [0:LANES-1] = '{1'b1, 1'b0, 1'b0, 1'b1};

  // floor(m*m/40) for m below the soft zone, upper entries unused
  localparam logic [5:0] SOFT_SPEED [0:63] = '{
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd1,
    6'd1,  6'd2,  6'd2,  6'd3,  6'd3,  6'd4,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd14, 6'd15, 6'd16, 6'd18, 6'd19, 6'd21, 6'd22, 6'd24,
    6'd25, 6'd27, 6'd28, 6'd30, 6'd32, 6'd34, 6'd36, 6'd38,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

endpackage
`default_nettype wire

// ===== src/sap_lane.sv =====
`default_nettype none
module sap_lane
  import sap_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sap_cfg_t           cfg,
  input  wire sap_ctrl_t          ctrl,
  input  wire logic               in_park,
  input  wire logic [ANGLE_W-1:0] angle,
  input  wire logic signed [11:0] base,
  input  wire logic signed [10:0] yaw2,
  input  wire logic [ANGLE_W-1:0] mid,
  input  wire logic               yaw_neg,
  output logic [ANGLE_W-1:0]      target
);

  // stage 1: park speed request and the finished level target
  logic signed [12:0] err;
  logic [11:0]        mag;
  logic               hard;
  logic [11:0]        spd;
  logic [7:0]         dmag;
  logic signed [8:0]  desired;

  logic signed [13:0] yaw_term;
  logic signed [13:0] goal;
  logic signed [13:0] dlt;
  logic [12:0]        absd;
  logic signed [13:0] cur;
  logic [11:0]        lvl_tgt;

  always_comb begin
    err  = $signed({1'b0, cfg.park_angle}) - $signed({1'b0, angle});
    mag  = err[12] ? 12'(-err) : err[11:0];
    hard = (mag <= {6'd0, cfg.snap_zone});
    if (mag < {6'd0, SOFT_ZONE}) begin
      spd = {6'd0, SOFT_SPEED[mag[5:0]]};
    end else begin
      spd = mag;
    end
    dmag    = (spd > {4'd0, cfg.vel_cap}) ? cfg.vel_cap : spd[7:0];
    desired = err[12] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

    yaw_term = yaw_neg ? -14'(yaw2) : 14'(yaw2);
    goal     = $signed({2'b00, mid}) + 14'(base) + yaw_term;
    dlt      = goal - $signed({2'b00, angle});
    absd     = dlt[13] ? 13'(-dlt) : dlt[12:0];
    if (absd < {5'd0, cfg.level_max_step}) begin
      cur = goal;
    end else if (dlt[13]) begin
      cur = $signed({2'b00, angle}) - $signed({6'd0, cfg.level_max_step});
    end else begin
      cur = $signed({2'b00, angle}) + $signed({6'd0, cfg.level_max_step});
    end
    if (cur[13]) begin
      lvl_tgt = '0;
    end else if (cur > $signed({2'b00, ANGLE_MAX})) begin
      lvl_tgt = ANGLE_MAX;
    end else begin
      lvl_tgt = cur[11:0];
    end
  end

  logic                   s1_hard_r;
  logic signed [8:0]      s1_desired_r;
  logic [ANGLE_W-1:0]     s1_angle_r;
  logic [ANGLE_W-1:0]     s1_fixed_r;   // park angle for a park tick, else level target

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s1_hard_r    <= hard;
      s1_desired_r <= desired;
      s1_angle_r   <= angle;
      s1_fixed_r   <= in_park ? cfg.park_angle : lvl_tgt;
    end
  end

  // stage 2: velocity slew against the stored velocity
  logic signed [VEL_W-1:0] vel_r;
  logic signed [VEL_W-1:0] vel_nxt;
  logic signed [VEL_W-1:0] vbase;
  logic signed [9:0]       dv;
  logic signed [9:0]       lim;
  logic signed [9:0]       dc;
  logic signed [VEL_W-1:0] vnew;
  logic signed [13:0]      pos;
  logic [ANGLE_W-1:0]      park_tgt;

  always_comb begin
    vbase = ctrl.clr_vel ? '0 : vel_r;
    dv    = 10'(s1_desired_r) - 10'(vbase);
    lim   = $signed({2'b00, cfg.acc_cap});
    if (dv > lim) begin
      dc = lim;
    end else if (dv < -lim) begin
      dc = -lim;
    end else begin
      dc = dv;
    end
    vnew = vbase + dc[VEL_W-1:0];
    pos  = $signed({2'b00, s1_angle_r}) + 14'(vnew);
    if (pos[13]) begin
      park_tgt = '0;
    end else if (pos > $signed({2'b00, ANGLE_MAX})) begin
      park_tgt = ANGLE_MAX;
    end else begin
      park_tgt = pos[11:0];
    end

    vel_nxt = vel_r;
    if (ctrl.adv && ctrl.park) begin
      vel_nxt = s1_hard_r ? '0 : vnew;
    end

    if (ctrl.park && !s1_hard_r) begin
      target = park_tgt;
    end else begin
      target = s1_fixed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r <= '0;
    end else begin
      vel_r <= vel_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/four_axis_setpoint_profiler.sv =====
// Setpoint profiler for four joint axes. Each input beat is one control tick
// (mode, four measured angles, yaw and two pilot offsets) and yields exactly
// one result beat with four new target angles, saturated to 0..4095. Park
// mode drives every axis to park_angle through a velocity profile with a
// hard snap zone, a quadratic soft zone of 40, a velocity clamp and an
// acceleration slew; level mode moves each axis toward its midpoint plus the
// offsets and the doubled yaw by at most level_max_step. The four axes run in
// parallel lanes through two register stages: stage 1 forms the park speed
// request and the level target, stage 2 slews the per-axis velocity and the
// output register collects the lanes. A new tick is taken every cycle while
// the output is not stalled, and the loop through the velocity registers is
// what sets that rate. While a result beat waits on out_stall one more tick
// is still accepted into stage 1. Configuration is always ready (cfg_ready
// is tied high) and must only be written while the block holds no ticks.
`default_nettype none
module four_axis_setpoint_profiler
  import sap_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [11:0] in_angle_front_right,
  input  wire logic [11:0] in_angle_back_left,
  input  wire logic [11:0] in_angle_front_left,
  input  wire logic [11:0] in_angle_back_right,
  input  wire logic signed [9:0]  in_yaw,
  input  wire logic signed [10:0] in_offset_coarse,
  input  wire logic signed [10:0] in_offset_fine,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_target_front_right,
  output logic [11:0]      out_target_back_left,
  output logic [11:0]      out_target_front_left,
  output logic [11:0]      out_target_back_right,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  // configuration registers
  sap_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.park_angle     <= 12'd1024;
      cfg_r.vel_cap        <= 8'd60;
      cfg_r.acc_cap        <= 8'd8;
      cfg_r.snap_zone      <= 6'd10;
      cfg_r.level_max_step <= 8'd60;
    end else if (cfg_valid && cfg_ready) begin
      case (sap_cfg_idx_t'(cfg_index))
        CFG_PARK_ANGLE:     cfg_r.park_angle     <= cfg_data;
        CFG_VEL_CAP:        cfg_r.vel_cap        <= cfg_data[7:0];
        CFG_ACC_CAP:        cfg_r.acc_cap        <= cfg_data[7:0];
        CFG_SNAP_ZONE:      cfg_r.snap_zone      <= cfg_data[5:0];
        CFG_LEVEL_MAX_STEP: cfg_r.level_max_step <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: output register frees when empty or being taken,
  // stage 1 moves on whenever the output register frees
  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_park_r;
  logic      out_valid_r, out_valid_nxt;
  logic      prev_park_r;       // last tick through stage 2 was park
  logic      out_free;
  sap_ctrl_t ctrl;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    ctrl.adv      = s1_valid_r && out_free;
    in_stall      = s1_valid_r && !out_free;
    ctrl.load     = in_valid && !in_stall;
    ctrl.park     = s1_park_r;
    // velocities clear on every entry into park
    ctrl.clr_vel  = s1_park_r && !prev_park_r;
    s1_valid_nxt  = ctrl.load || (s1_valid_r && !ctrl.adv);
    out_valid_nxt = ctrl.adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_park_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctrl.adv) begin
        prev_park_r <= s1_park_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s1_park_r <= !in_mode;
    end
  end

  // tick-wide terms shared by every lane
  logic signed [11:0] base;
  logic signed [10:0] yaw2;

  assign base = 12'(in_offset_coarse) + 12'(in_offset_fine);
  assign yaw2 = {in_yaw, 1'b0};

  logic [ANGLE_W-1:0] angle_in [0:LANES-1];
  logic [ANGLE_W-1:0] lane_tgt [0:LANES-1];

  assign angle_in[0] = in_angle_front_right;
  assign angle_in[1] = in_angle_back_left;
  assign angle_in[2] = in_angle_front_left;
  assign angle_in[3] = in_angle_back_right;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < AXES) begin : g_axis
      sap_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_r),
        .ctrl    (ctrl),
        .in_park (!in_mode),
        .angle   (angle_in[i]),
        .base    (base),
        .yaw2    (yaw2),
        .mid     (LANE_MID[i]),
        .yaw_neg (LANE_YAW_NEG[i]),
        .target  (lane_tgt[i])
      );
    end else begin : g_unused
      // axes beyond the configured count report zero
      assign lane_tgt[i] = '0;
    end
  end

  // merge: the output register collects all lane targets into one beat
  logic [ANGLE_W-1:0] out_tgt_r [0:LANES-1];

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      for (int k = 0; k < LANES; k++) begin
        out_tgt_r[k] <= lane_tgt[k];
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_target_front_right = out_tgt_r[0];
  assign out_target_back_left   = out_tgt_r[1];
  assign out_target_front_left  = out_tgt_r[2];
  assign out_target_back_right  = out_tgt_r[3];

  // input only held back while both stages are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  // a fresh result beat must come from a stage 1 item
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall) ##1 out_valid_r |-> $past(s1_valid_r))
    else $error("result beat without a stage 1 item");

  // park history follows the tick that last left stage 1
  a_prev_park: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.adv |=> (prev_park_r == $past(s1_park_r)))
    else $error("park history not updated");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top
  import sap_pkg::*;
;

  // long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 200;
  // far above the slowest legal run (every beat waiting out full gaps and stalls)
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_TICKS = 160;
  localparam int N_PHASES    = 9;

  // level goals per axis, right axes take the doubled yaw negated
  localparam int LEVEL_MID [4] = '{2030, 2060, 2054, 2000};
  localparam int YAW_SIGN  [4] = '{-1, 1, 1, -1};

  // one control tick; angle[0] is front right, then back left, front left, back right
  typedef struct packed {
    logic               mode;
    logic [3:0][11:0]   angle;
    logic signed [9:0]  yaw;
    logic signed [10:0] off_coarse;
    logic signed [10:0] off_fine;
  } tick_t;

  typedef logic [3:0][11:0] targets_t;

  // tracks the profiler's registers, velocities and the targets still owed
  class setpoint_predictor;
    int       park_angle, max_vel, accel_lim, hard_dz, level_step;
    int       vel [4];
    int       prev_mode;
    targets_t last_targets;
    targets_t pending_targets [$];
    int       mismatches;

    function new();
      park_angle = 1024;
      max_vel    = 60;
      accel_lim  = 8;
      hard_dz    = 10;
      level_step = 60;
      foreach (vel[i]) vel[i] = 0;
      prev_mode    = 3;
      last_targets = '0;
      mismatches   = 0;
    endfunction

    static function int bound(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(sap_cfg_idx_t idx, logic [11:0] val);
      case (idx)
        CFG_PARK_ANGLE:     park_angle = int'(val);
        CFG_VEL_CAP:        max_vel    = int'(val[7:0]);
        CFG_ACC_CAP:        accel_lim  = int'(val[7:0]);
        CFG_SNAP_ZONE:      hard_dz    = int'(val[5:0]);
        CFG_LEVEL_MAX_STEP: level_step = int'(val[7:0]);
        default: ;
      endcase
    endfunction

    // works out the target beat for one accepted tick
    function void take_tick(tick_t t);
      int ang, err, mag, want, goal, yaw2, base;
      targets_t tgt;
      yaw2 = 2 * int'(t.yaw);
      base = int'(t.off_coarse) + int'(t.off_fine);
      // every entry into park starts from rest
      if (t.mode == 1'b0 && prev_mode != 0) foreach (vel[i]) vel[i] = 0;
      prev_mode = int'(t.mode);
      for (int i = 0; i < 4; i++) begin
        ang = int'(t.angle[i]);
        if (t.mode == 1'b0) begin
          err = park_angle - ang;
          mag = (err < 0) ? -err : err;
          if (mag <= hard_dz) begin
            vel[i] = 0;
            ang    = park_angle;
          end else begin
            want   = (mag < 40) ? (err * mag) / 40 : err;
            want   = bound(want, -max_vel, max_vel);
            vel[i] += bound(want - vel[i], -accel_lim, accel_lim);
            ang    = ang + vel[i];
          end
        end else begin
          goal = LEVEL_MID[i] + base + YAW_SIGN[i] * yaw2;
          if (ang < goal) ang += (goal - ang < level_step) ? goal - ang : level_step;
          else if (ang > goal) ang -= (ang - goal < level_step) ? ang - goal : level_step;
        end
        tgt[i] = 12'(bound(ang, 0, 4095));
      end
      last_targets = tgt;
      pending_targets.push_back(tgt);
    endfunction

    function void match_targets(targets_t got);
      targets_t want;
      if (pending_targets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("target beat with nothing owed: %h", got);
        return;
      end
      want = pending_targets.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[i] !== want[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("target of axis %0d: expected %0d, got %0d", i, want[i], got[i]);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = 1'b0;
  logic [11:0]        in_angle_front_right = '0;
  logic [11:0]        in_angle_back_left = '0;
  logic [11:0]        in_angle_front_left = '0;
  logic [11:0]        in_angle_back_right = '0;
  logic signed [9:0]  in_yaw = '0;
  logic signed [10:0] in_offset_coarse = '0;
  logic signed [10:0] in_offset_fine = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_target_front_right;
  logic [11:0] out_target_back_left;
  logic [11:0] out_target_front_left;
  logic [11:0] out_target_back_right;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  setpoint_predictor model = new();

  // set by the stimulus: hold_req asks for one long hold-off, calm stops all idling
  bit hold_req = 1'b0;
  bit calm     = 1'b0;
  int stall_left = 0;
  int cycles = 0;

  four_axis_setpoint_profiler dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_mode                (in_mode),
    .in_angle_front_right   (in_angle_front_right),
    .in_angle_back_left     (in_angle_back_left),
    .in_angle_front_left    (in_angle_front_left),
    .in_angle_back_right    (in_angle_back_right),
    .in_yaw                 (in_yaw),
    .in_offset_coarse       (in_offset_coarse),
    .in_offset_fine         (in_offset_fine),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_target_front_right (out_target_front_right),
    .out_target_back_left   (out_target_back_left),
    .out_target_front_left  (out_target_front_left),
    .out_target_back_right  (out_target_back_right),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request, none when calm
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every target beat taken is checked against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      model.match_targets({out_target_back_right, out_target_front_left,
                           out_target_back_left, out_target_front_right});
  end

  function automatic tick_t tick_of(logic mode, int a0, int a1, int a2, int a3,
                                    int yaw, int coarse, int fine);
    tick_t t;
    t.mode       = mode;
    t.angle      = {12'(a3), 12'(a2), 12'(a1), 12'(a0)};
    t.yaw        = 10'(yaw);
    t.off_coarse = 11'(coarse);
    t.off_fine   = 11'(fine);
    return t;
  endfunction

  // angles mostly follow the last targets (closed loop) or sit near park
  function automatic tick_t random_tick(logic mode);
    tick_t t;
    int pick, a;
    t.mode = mode;
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) a = int'(model.last_targets[i]) + int'($urandom_range(0, 8)) - 4;
      else if (pick < 7) a = model.park_angle + int'($urandom_range(0, 120)) - 60;
      else a = $urandom_range(0, 4095);
      t.angle[i] = 12'(setpoint_predictor::bound(a, 0, 4095));
    end
    t.yaw = 10'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      t.off_coarse = 11'($urandom);
      t.off_fine   = 11'($urandom);
    end else begin
      t.off_coarse = 11'(int'($urandom_range(0, 400)) - 200);
      t.off_fine   = 11'(int'($urandom_range(0, 100)) - 50);
    end
    return t;
  endfunction

  // one input beat, with a random gap ahead of it unless calm
  task automatic offer_tick(tick_t t);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_mode              <= t.mode;
    in_angle_front_right <= t.angle[0];
    in_angle_back_left   <= t.angle[1];
    in_angle_front_left  <= t.angle[2];
    in_angle_back_right  <= t.angle[3];
    in_yaw               <= t.yaw;
    in_offset_coarse     <= t.off_coarse;
    in_offset_fine       <= t.off_fine;
    do @(posedge clk); while (in_stall);
    model.take_tick(t);
  endtask

  // stop offering and let every owed beat come out, then a few spare cycles
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (model.pending_targets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(sap_cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 12'(val);
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, 12'(val));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_setting(int pa, int mv, int al, int hd, int ls);
    write_reg(CFG_PARK_ANGLE, pa);
    write_reg(CFG_VEL_CAP, mv);
    write_reg(CFG_ACC_CAP, al);
    write_reg(CFG_SNAP_ZONE, hd);
    write_reg(CFG_LEVEL_MAX_STEP, ls);
  endtask

  // mostly runs of one mode with random content, now and then a lone flip
  task automatic run_random(int n);
    int   run_left;
    logic mode;
    run_left = 0;
    mode     = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        mode     = ($urandom_range(0, 9) < 6) ? 1'b0 : 1'b1;
        run_left = $urandom_range(1, 30);
      end
      run_left--;
      if ($urandom_range(0, 19) == 0) offer_tick(random_tick(~mode));
      else offer_tick(random_tick(mode));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks under the reset settings
    // level mode: saturation at both ends, sitting on the goal, moves within a step
    offer_tick(tick_of(1'b1, 0, 0, 0, 0, -512, -1024, -1024));
    offer_tick(tick_of(1'b1, 4095, 4095, 4095, 4095, 511, 1023, 1023));
    offer_tick(tick_of(1'b1, 2030, 2060, 2054, 2000, 0, 0, 0));
    offer_tick(tick_of(1'b1, 2000, 2090, 2024, 2030, 0, 0, 0));
    offer_tick(tick_of(1'b1, 1000, 3000, 1000, 3000, -3, 17, -9));
    // entering park from far below, then the profile ramping up
    offer_tick(tick_of(1'b0, 0, 0, 0, 0, 0, 0, 0));
    offer_tick(tick_of(1'b0, 0, 0, 0, 0, 0, 0, 0));
    offer_tick(tick_of(1'b0, 100, 200, 300, 400, 0, 0, 0));
    offer_tick(tick_of(1'b0, 4095, 4095, 4095, 4095, 0, 0, 0));
    // hard deadzone edges and the quadratic soft zone
    offer_tick(tick_of(1'b0, 1014, 1034, 1024, 1013, 0, 0, 0));
    offer_tick(tick_of(1'b0, 1035, 1013, 1063, 985, 0, 0, 0));
    offer_tick(tick_of(1'b0, 1064, 984, 1044, 1004, 0, 0, 0));
    offer_tick(tick_of(1'b0, 1050, 1000, 1060, 990, 0, 0, 0));
    // leave park and come back: velocities must start from rest again
    offer_tick(tick_of(1'b1, 1050, 1000, 1060, 990, 100, -200, 50));
    offer_tick(tick_of(1'b0, 500, 1500, 500, 1500, 0, 0, 0));
    offer_tick(tick_of(1'b0, 500, 1500, 500, 1500, 0, 0, 0));
    offer_tick(tick_of(1'b1, 2048, 2048, 2048, 2048, -1, -1, -1));
    offer_tick(tick_of(1'b0, 2048, 2048, 2048, 2048, 0, 0, 0));
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_setting(0, 255, 255, 0, 255);        // extremes: caps high, park angle and snap zone zero
        1: write_setting(4095, 0, 0, 39, 0);          // zero limits, widest soft snap
        2: write_setting(2048, 255, 1, 63, 1);        // deadzone swallows the soft zone
        3: write_setting(1024, 60, 8, 10, 60);
        default: write_setting($urandom_range(0, 4095), $urandom_range(1, 255),
                               $urandom_range(1, 40), $urandom_range(0, 39),
                               $urandom_range(0, 255));
      endcase
      // fill the pipe behind a long receiver hold-off
      if (p == 3) hold_req = 1'b1;
      if (p == N_PHASES - 1) calm = 1'b1;
      run_random(PHASE_TICKS);
      drain();
    end

    if (model.mismatches == 0 && model.pending_targets.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
